FILE: sv/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types and constants for the packet dedupe and flood relay block.
// ----------------------------------------------------------------------------
package dfr_pkg;

    localparam int RING_DEPTH_DEF      = 4;
    localparam int NEIGHBOUR_SLOTS_DEF = 8;

    localparam int SEQ_W     = 16;
    localparam int HOP_W     = 4;
    localparam int SHADER_W  = 8;
    localparam int FEAT_W    = 64;
    localparam int MAC_W     = 48;
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 32;
    localparam int STALE_W   = 16;
    localparam int WINDOW_W  = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [STALE_W-1:0]  STALE_MS_RST       = 16'd300;
    localparam logic [WINDOW_W-1:0] REORDER_WINDOW_RST = 15'd256;
    localparam logic [HOP_W-1:0]    MAX_HOP_RST        = 4'd3;

    localparam logic ACT_PACKET = 1'b0;
    localparam logic ACT_DRAIN  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STALE_MS       = 2'd0,
        CFG_REORDER_WINDOW = 2'd1,
        CFG_MAX_HOP        = 2'd2
    } dfr_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_LOOKUP,
        ST_COMPARE,
        ST_COMMIT
    } dfr_state_t;

    typedef struct packed {
        logic load;
        logic decide;
        logic compare;
        logic advance;
        logic commit;
    } dfr_cmd_t;

    typedef struct packed {
        logic is_drain;
        logic take;
        logic hit;
        logic scan_last;
    } dfr_sts_t;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [HOP_W-1:0]    hop;
        logic [SHADER_W-1:0] shader;
        logic [FEAT_W-1:0]   feat_lo;
        logic [FEAT_W-1:0]   feat_hi;
    } dfr_ring_entry_t;

    typedef struct packed {
        logic [MAC_W-1:0]   mac;
        logic [COUNT_W-1:0] count;
    } dfr_nb_entry_t;

endpackage

FILE: sv/dfr_ram.sv
// ----------------------------------------------------------------------------
// dfr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/dfr_ctrl.sv
// ----------------------------------------------------------------------------
// dfr_ctrl
// Request sequencer: decide, walk the neighbour table, commit.
// ----------------------------------------------------------------------------
module dfr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  dfr_pkg::dfr_sts_t  sts,
    output dfr_pkg::dfr_cmd_t  cmd,
    output logic               busy
);
    import dfr_pkg::*;

    dfr_state_t state_reg;
    dfr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (sts.is_drain || !sts.take)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                if (sts.hit || sts.scan_last)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/dfr_datapath.sv
// ----------------------------------------------------------------------------
// dfr_datapath
// Freshness check, neighbour table, relay ring, configuration and results.
// ----------------------------------------------------------------------------
module dfr_datapath #(
    parameter int RING_DEPTH      = dfr_pkg::RING_DEPTH_DEF,
    parameter int NEIGHBOUR_SLOTS = dfr_pkg::NEIGHBOUR_SLOTS_DEF,
    localparam int SLOT_W = $clog2(NEIGHBOUR_SLOTS + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dfr_pkg::dfr_cmd_t                   cmd,
    output dfr_pkg::dfr_sts_t                   sts,
    input  logic                                cfg_we,
    input  logic [dfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dfr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                action,
    input  logic [dfr_pkg::TIME_W-1:0]          now_ms,
    input  logic                                packet_ok,
    input  logic [dfr_pkg::MAC_W-1:0]           sender_mac,
    input  logic [dfr_pkg::SEQ_W-1:0]           seq,
    input  logic [dfr_pkg::HOP_W-1:0]           hop,
    input  logic [dfr_pkg::SHADER_W-1:0]        shader,
    input  logic [dfr_pkg::FEAT_W-1:0]          features_low,
    input  logic [dfr_pkg::FEAT_W-1:0]          features_high,
    output logic                                done,
    output logic                                accepted,
    output logic                                resync,
    output logic                                relay_queued,
    output logic                                relay_dropped,
    output logic [SLOT_W-1:0]                   source_slot,
    output logic [dfr_pkg::COUNT_W-1:0]         source_count,
    output logic                                relay_valid,
    output logic [dfr_pkg::SEQ_W-1:0]           relay_seq,
    output logic [dfr_pkg::HOP_W-1:0]           relay_hop,
    output logic [dfr_pkg::SHADER_W-1:0]        relay_shader,
    output logic [dfr_pkg::FEAT_W-1:0]          relay_features_low,
    output logic [dfr_pkg::FEAT_W-1:0]          relay_features_high
);
    import dfr_pkg::*;

    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int NB_AW   = (NEIGHBOUR_SLOTS > 1) ? $clog2(NEIGHBOUR_SLOTS) : 1;
    localparam logic [SLOT_W-1:0]  SLOT_NONE = SLOT_W'(NEIGHBOUR_SLOTS);
    localparam logic [NB_AW-1:0]   IDX_LAST  = NB_AW'(NEIGHBOUR_SLOTS - 1);
    localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);

    // configuration
    logic [STALE_W-1:0]  stale_ms_reg;
    logic [WINDOW_W-1:0] reorder_window_reg;
    logic [HOP_W-1:0]    max_hop_reg;

    // latched request
    logic                action_reg;
    logic [TIME_W-1:0]   now_reg;
    logic                ok_reg;
    logic [MAC_W-1:0]    mac_reg;
    logic [SEQ_W-1:0]    seq_reg;
    logic [HOP_W-1:0]    hop_reg;
    logic [SHADER_W-1:0] shader_reg;
    logic [FEAT_W-1:0]   flo_reg;
    logic [FEAT_W-1:0]   fhi_reg;
    logic                resync_hold_reg;

    // dedupe and table state
    logic [SEQ_W-1:0]           last_seq_reg;
    logic                       seen_reg;
    logic [TIME_W-1:0]          last_time_reg;
    logic [RING_AW-1:0]         head_reg;
    logic [RING_AW-1:0]         tail_reg;
    logic [NEIGHBOUR_SLOTS-1:0] used_reg;
    logic [NB_AW-1:0]           idx_reg;
    logic                       hit_reg;

    // results
    logic                 done_reg;
    logic                 res_accepted_reg,  res_accepted_next;
    logic                 res_resync_reg,    res_resync_next;
    logic                 res_queued_reg,    res_queued_next;
    logic                 res_dropped_reg,   res_dropped_next;
    logic [SLOT_W-1:0]    res_slot_reg,      res_slot_next;
    logic [COUNT_W-1:0]   res_count_reg,     res_count_next;
    logic                 res_rvalid_reg,    res_rvalid_next;
    logic [SEQ_W-1:0]     res_rseq_reg,      res_rseq_next;
    logic [HOP_W-1:0]     res_rhop_reg,      res_rhop_next;
    logic [SHADER_W-1:0]  res_rshader_reg,   res_rshader_next;
    logic [FEAT_W-1:0]    res_rflo_reg,      res_rflo_next;
    logic [FEAT_W-1:0]    res_rfhi_reg,      res_rfhi_next;

    // freshness
    logic [SEQ_W-1:0]    diff;
    logic signed [SEQ_W:0] delta_s;
    logic signed [SEQ_W:0] window_s;
    logic [TIME_W-1:0]   gap;
    logic                newer;
    logic                silence;
    logic                epoch;
    logic                take;
    logic                is_drain;

    assign is_drain = (action_reg == ACT_DRAIN);
    assign diff     = seq_reg - last_seq_reg;
    assign delta_s  = $signed({diff[SEQ_W-1], diff});
    assign window_s = -$signed({2'b00, reorder_window_reg});
    assign epoch    = delta_s < window_s;
    assign newer    = !diff[SEQ_W-1] && (diff != '0);
    assign gap      = now_reg - last_time_reg;
    assign silence  = gap > {{(TIME_W - STALE_W){1'b0}}, stale_ms_reg};
    assign take     = ok_reg && (!seen_reg || newer || silence || epoch);

    // neighbour table
    dfr_nb_entry_t    nb_rd;
    dfr_nb_entry_t    nb_wr;
    logic             nb_we;
    logic [NB_AW-1:0] nb_waddr;
    logic             hit_now;
    logic             free_found;
    logic [NB_AW-1:0] free_idx;
    logic [COUNT_W-1:0] nb_inc;

    dfr_ram #(
        .WIDTH ($bits(dfr_nb_entry_t)),
        .DEPTH (NEIGHBOUR_SLOTS)
    ) u_nb_ram (
        .clk   (clk),
        .we    (nb_we),
        .waddr (nb_waddr),
        .wdata (nb_wr),
        .raddr (idx_reg),
        .rdata (nb_rd)
    );

    assign hit_now = used_reg[idx_reg] && (nb_rd.mac == mac_reg);
    assign nb_inc  = (nb_rd.count == '1) ? nb_rd.count : nb_rd.count + 1'b1;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NEIGHBOUR_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = NB_AW'(i);
            end
        end
    end

    assign nb_we     = cmd.commit && (hit_reg || free_found);
    assign nb_waddr  = hit_reg ? idx_reg : free_idx;
    assign nb_wr.mac = mac_reg;
    assign nb_wr.count = hit_reg ? nb_inc : COUNT_W'(1);

    // relay ring
    dfr_ring_entry_t    ring_rd;
    dfr_ring_entry_t    ring_wr;
    logic [RING_AW-1:0] head_inc;
    logic [RING_AW-1:0] tail_inc;
    logic               want_relay;
    logic               ring_full;
    logic               ring_empty;
    logic               ring_we;
    logic               pop;

    dfr_ram #(
        .WIDTH ($bits(dfr_ring_entry_t)),
        .DEPTH (RING_DEPTH)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (head_reg),
        .wdata (ring_wr),
        .raddr (tail_reg),
        .rdata (ring_rd)
    );

    assign head_inc   = (head_reg == RING_LAST) ? '0 : head_reg + 1'b1;
    assign tail_inc   = (tail_reg == RING_LAST) ? '0 : tail_reg + 1'b1;
    assign want_relay = hop_reg < max_hop_reg;
    assign ring_full  = (head_inc == tail_reg);
    assign ring_empty = (head_reg == tail_reg);
    assign ring_we    = cmd.commit && want_relay && !ring_full;
    assign pop        = cmd.decide && is_drain && !ring_empty;

    assign ring_wr.seq     = seq_reg;
    assign ring_wr.hop     = hop_reg + 1'b1;
    assign ring_wr.shader  = shader_reg;
    assign ring_wr.feat_lo = flo_reg;
    assign ring_wr.feat_hi = fhi_reg;

    // status
    assign sts.is_drain  = is_drain;
    assign sts.take      = take;
    assign sts.hit       = hit_now;
    assign sts.scan_last = (idx_reg == IDX_LAST);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_ms_reg       <= STALE_MS_RST;
            reorder_window_reg <= REORDER_WINDOW_RST;
            max_hop_reg        <= MAX_HOP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STALE_MS:       stale_ms_reg       <= cfg_data[STALE_W-1:0];
                CFG_REORDER_WINDOW: reorder_window_reg <= cfg_data[WINDOW_W-1:0];
                CFG_MAX_HOP:        max_hop_reg        <= cfg_data[HOP_W-1:0];
                default:            ;
            endcase
        end
    end

    // latch request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            now_reg    <= now_ms;
            ok_reg     <= packet_ok;
            mac_reg    <= sender_mac;
            seq_reg    <= seq;
            hop_reg    <= hop;
            shader_reg <= shader;
            flo_reg    <= features_low;
            fhi_reg    <= features_high;
        end
        if (cmd.decide)
        begin
            resync_hold_reg <= silence || epoch;
        end
    end

    // dedupe, ring pointers, table walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seq_reg  <= '0;
            seen_reg      <= 1'b0;
            last_time_reg <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            used_reg      <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.decide)
            begin
                idx_reg <= '0;
                if (!is_drain && take)
                begin
                    last_seq_reg  <= seq_reg;
                    seen_reg      <= 1'b1;
                    last_time_reg <= now_reg;
                end
            end
            if (pop)
            begin
                tail_reg <= tail_inc;
            end
            if (cmd.compare)
            begin
                hit_reg <= hit_now;
            end
            if (cmd.advance)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (ring_we)
            begin
                head_reg <= head_inc;
            end
            if (cmd.commit && !hit_reg && free_found)
            begin
                used_reg[free_idx] <= 1'b1;
            end
        end
    end

    // results
    always_comb
    begin
        res_accepted_next = 1'b0;
        res_resync_next   = 1'b0;
        res_queued_next   = 1'b0;
        res_dropped_next  = 1'b0;
        res_slot_next     = SLOT_NONE;
        res_count_next    = '0;
        res_rvalid_next   = 1'b0;
        res_rseq_next     = '0;
        res_rhop_next     = '0;
        res_rshader_next  = '0;
        res_rflo_next     = '0;
        res_rfhi_next     = '0;
        if (cmd.commit)
        begin
            res_accepted_next = 1'b1;
            res_resync_next   = resync_hold_reg;
            res_queued_next   = ring_we;
            res_dropped_next  = want_relay && ring_full;
            if (hit_reg)
            begin
                res_slot_next  = SLOT_W'(idx_reg);
                res_count_next = nb_inc;
            end
            else if (free_found)
            begin
                res_slot_next  = SLOT_W'(free_idx);
                res_count_next = COUNT_W'(1);
            end
        end
        else if (pop)
        begin
            res_rvalid_next  = 1'b1;
            res_rseq_next    = ring_rd.seq;
            res_rhop_next    = ring_rd.hop;
            res_rshader_next = ring_rd.shader;
            res_rflo_next    = ring_rd.feat_lo;
            res_rfhi_next    = ring_rd.feat_hi;
        end
    end

    logic finish;
    assign finish = (cmd.decide && (is_drain || !take)) || cmd.commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            res_accepted_reg <= res_accepted_next;
            res_resync_reg   <= res_resync_next;
            res_queued_reg   <= res_queued_next;
            res_dropped_reg  <= res_dropped_next;
            res_slot_reg     <= res_slot_next;
            res_count_reg    <= res_count_next;
            res_rvalid_reg   <= res_rvalid_next;
            res_rseq_reg     <= res_rseq_next;
            res_rhop_reg     <= res_rhop_next;
            res_rshader_reg  <= res_rshader_next;
            res_rflo_reg     <= res_rflo_next;
            res_rfhi_reg     <= res_rfhi_next;
        end
    end

    assign done                = done_reg;
    assign accepted            = res_accepted_reg;
    assign resync              = res_resync_reg;
    assign relay_queued        = res_queued_reg;
    assign relay_dropped       = res_dropped_reg;
    assign source_slot         = res_slot_reg;
    assign source_count        = res_count_reg;
    assign relay_valid         = res_rvalid_reg;
    assign relay_seq           = res_rseq_reg;
    assign relay_hop           = res_rhop_reg;
    assign relay_shader        = res_rshader_reg;
    assign relay_features_low  = res_rflo_reg;
    assign relay_features_high = res_rfhi_reg;

endmodule

FILE: sv/packet_dedupe_and_flood_relay_top.sv
// A drain or a rejected packet finishes in DECIDE; done is registered from that finish.
//   An accepted packet first walks k table slots, k <= NEIGHBOUR_SLOTS, then commits.
// Requests are taken one at a time: busy stays high until the request finishes, so
//   the neighbour table walk (one slot per LOOKUP and COMPARE, one read port) holds it off.
// The next request is taken in the cycle its predecessor's result is shown.
// Reset (async, active low) clears control state and loads register defaults at once.
// ----------------------------------------------------------------------------
// packet_dedupe_and_flood_relay_top
// Sequence-window packet dedupe with neighbour counting and a flood relay ring.
// ----------------------------------------------------------------------------
module packet_dedupe_and_flood_relay_top #(
    parameter int RING_DEPTH      = dfr_pkg::RING_DEPTH_DEF,
    parameter int NEIGHBOUR_SLOTS = dfr_pkg::NEIGHBOUR_SLOTS_DEF,
    localparam int SLOT_W = $clog2(NEIGHBOUR_SLOTS + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dfr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           action,
    input  logic [dfr_pkg::TIME_W-1:0]     now_ms,
    input  logic                           packet_ok,
    input  logic [dfr_pkg::MAC_W-1:0]      sender_mac,
    input  logic [dfr_pkg::SEQ_W-1:0]      seq,
    input  logic [dfr_pkg::HOP_W-1:0]      hop,
    input  logic [dfr_pkg::SHADER_W-1:0]   shader,
    input  logic [dfr_pkg::FEAT_W-1:0]     features_low,
    input  logic [dfr_pkg::FEAT_W-1:0]     features_high,
    output logic                           done,
    output logic                           accepted,
    output logic                           resync,
    output logic                           relay_queued,
    output logic                           relay_dropped,
    output logic [SLOT_W-1:0]              source_slot,
    output logic [dfr_pkg::COUNT_W-1:0]    source_count,
    output logic                           relay_valid,
    output logic [dfr_pkg::SEQ_W-1:0]      relay_seq,
    output logic [dfr_pkg::HOP_W-1:0]      relay_hop,
    output logic [dfr_pkg::SHADER_W-1:0]   relay_shader,
    output logic [dfr_pkg::FEAT_W-1:0]     relay_features_low,
    output logic [dfr_pkg::FEAT_W-1:0]     relay_features_high
);
    import dfr_pkg::*;

    dfr_cmd_t cmd;
    dfr_sts_t sts;
    logic     cfg_we;

    assign cfg_ready = !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    dfr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    dfr_datapath #(
        .RING_DEPTH      (RING_DEPTH),
        .NEIGHBOUR_SLOTS (NEIGHBOUR_SLOTS)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .action              (action),
        .now_ms              (now_ms),
        .packet_ok           (packet_ok),
        .sender_mac          (sender_mac),
        .seq                 (seq),
        .hop                 (hop),
        .shader              (shader),
        .features_low        (features_low),
        .features_high       (features_high),
        .done                (done),
        .accepted            (accepted),
        .resync              (resync),
        .relay_queued        (relay_queued),
        .relay_dropped       (relay_dropped),
        .source_slot         (source_slot),
        .source_count        (source_count),
        .relay_valid         (relay_valid),
        .relay_seq           (relay_seq),
        .relay_hop           (relay_hop),
        .relay_shader        (relay_shader),
        .relay_features_low  (relay_features_low),
        .relay_features_high (relay_features_high)
    );

endmodule

FILE: sv/dfr_checker.sv
// ----------------------------------------------------------------------------
// dfr_checker
// Port-level checks on request and result behavior of the top level.
// ----------------------------------------------------------------------------
module dfr_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic accepted,
    input logic resync,
    input logic relay_queued,
    input logic relay_dropped,
    input logic relay_valid
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_drain_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done && relay_valid |-> !accepted)
        else $error("drain result carries packet acceptance");

    a_reject_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done && !accepted |-> !(relay_queued || relay_dropped || resync))
        else $error("flags set on a packet that was not accepted");

    a_queue_drop: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(relay_queued && relay_dropped))
        else $error("packet both queued and dropped");

endmodule

bind packet_dedupe_and_flood_relay_top dfr_checker u_dfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .accepted      (accepted),
    .resync        (resync),
    .relay_queued  (relay_queued),
    .relay_dropped (relay_dropped),
    .relay_valid   (relay_valid)
);

FILE: sim/dedupe_relay_checker.sv
// ----------------------------------------------------------------------------
// dedupe_relay_checker
// Watches the request, register and result channels of the dedupe and relay
// block. It keeps its own copy of the sequence window, neighbour table and
// relay ring, predicts one verdict per accepted request, and compares every
// result strobe field by field with the oldest verdict that is waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dedupe_relay_checker (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               start,
    input  logic                                               busy,
    input  logic                                               cfg_valid,
    input  logic                                               cfg_ready,
    input  logic [dfr_pkg::CFG_IDX_W-1:0]                      cfg_index,
    input  logic [dfr_pkg::CFG_DATA_W-1:0]                     cfg_data,
    input  logic                                               action,
    input  logic [dfr_pkg::TIME_W-1:0]                         now_ms,
    input  logic                                               packet_ok,
    input  logic [dfr_pkg::MAC_W-1:0]                          sender_mac,
    input  logic [dfr_pkg::SEQ_W-1:0]                          seq,
    input  logic [dfr_pkg::HOP_W-1:0]                          hop,
    input  logic [dfr_pkg::SHADER_W-1:0]                       shader,
    input  logic [dfr_pkg::FEAT_W-1:0]                         features_low,
    input  logic [dfr_pkg::FEAT_W-1:0]                         features_high,
    input  logic                                               done,
    input  logic                                               accepted,
    input  logic                                               resync,
    input  logic                                               relay_queued,
    input  logic                                               relay_dropped,
    input  logic [$clog2(dfr_pkg::NEIGHBOUR_SLOTS_DEF+1)-1:0]  source_slot,
    input  logic [dfr_pkg::COUNT_W-1:0]                        source_count,
    input  logic                                               relay_valid,
    input  logic [dfr_pkg::SEQ_W-1:0]                          relay_seq,
    input  logic [dfr_pkg::HOP_W-1:0]                          relay_hop,
    input  logic [dfr_pkg::SHADER_W-1:0]                       relay_shader,
    input  logic [dfr_pkg::FEAT_W-1:0]                         relay_features_low,
    input  logic [dfr_pkg::FEAT_W-1:0]                         relay_features_high,
    output int                                                 outstanding,
    output int                                                 fail_count
);
    import dfr_pkg::*;

    localparam int RING_N    = RING_DEPTH_DEF;
    localparam int SLOTS     = NEIGHBOUR_SLOTS_DEF;
    localparam int SLOT_BITS = $clog2(SLOTS + 1);
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                 accepted;
        logic                 resync;
        logic                 queued;
        logic                 dropped;
        logic [SLOT_BITS-1:0] slot;
        logic [COUNT_W-1:0]   count;
        logic                 relay_valid;
        logic [SEQ_W-1:0]     seq;
        logic [HOP_W-1:0]     hop;
        logic [SHADER_W-1:0]  shader;
        logic [FEAT_W-1:0]    flo;
        logic [FEAT_W-1:0]    fhi;
    } relay_verdict_t;

    logic [STALE_W-1:0]  stale_ms_q;
    logic [WINDOW_W-1:0] window_q;
    logic [HOP_W-1:0]    max_hop_q;

    logic [SEQ_W-1:0]    last_seq;
    logic                seen_any;
    logic [TIME_W-1:0]   last_accept_ms;
    int                  ring_rd;
    int                  ring_wr;
    dfr_ring_entry_t     ring [RING_N];
    logic [MAC_W-1:0]    nb_mac [SLOTS];
    logic [COUNT_W-1:0]  nb_count [SLOTS];
    logic                nb_used [SLOTS];

    relay_verdict_t      verdict_q [$];
    relay_verdict_t      want;
    relay_verdict_t      fresh_verdict;
    int                  k;

    task automatic predict_verdict(output relay_verdict_t v);
        logic [SEQ_W-1:0]        diff;
        logic signed [SEQ_W-1:0] lag;
        logic [TIME_W-1:0]       quiet;
        logic                    silence;
        logic                    epoch;
        int                      delta;
        int                      win;
        int                      slot;
        int                      i;
        dfr_ring_entry_t         entry;
        v = '0;
        v.slot = SLOTS[SLOT_BITS-1:0];
        if (action == ACT_DRAIN) begin
            if (ring_rd != ring_wr) begin
                v.relay_valid = 1'b1;
                v.seq         = ring[ring_rd].seq;
                v.hop         = ring[ring_rd].hop;
                v.shader      = ring[ring_rd].shader;
                v.flo         = ring[ring_rd].feat_lo;
                v.fhi         = ring[ring_rd].feat_hi;
                ring_rd       = (ring_rd + 1) % RING_N;
            end
        end else if (packet_ok) begin
            diff    = seq - last_seq;
            lag     = diff;
            delta   = int'(lag);
            win     = int'(window_q);
            quiet   = now_ms - last_accept_ms;
            silence = quiet > TIME_W'(stale_ms_q);
            epoch   = delta < -win;
            if (!seen_any || delta > 0 || silence || epoch) begin
                v.accepted     = 1'b1;
                v.resync       = silence || epoch;
                last_seq       = seq;
                seen_any       = 1'b1;
                last_accept_ms = now_ms;

                slot = SLOTS;
                for (i = 0; i < SLOTS; i++)
                    if (slot == SLOTS && nb_used[i] && nb_mac[i] == sender_mac)
                        slot = i;
                for (i = 0; i < SLOTS; i++)
                    if (slot == SLOTS && !nb_used[i])
                    begin
                        slot        = i;
                        nb_used[i]  = 1'b1;
                        nb_mac[i]   = sender_mac;
                        nb_count[i] = '0;
                    end
                if (slot < SLOTS)
                begin
                    if (nb_count[slot] != '1)
                        nb_count[slot] = nb_count[slot] + 1'b1;
                    v.count = nb_count[slot];
                end
                v.slot = slot[SLOT_BITS-1:0];

                if (hop < max_hop_q)
                begin
                    if ((ring_wr + 1) % RING_N == ring_rd)
                        v.dropped = 1'b1;
                    else
                    begin
                        entry.seq     = seq;
                        entry.hop     = hop + 1'b1;
                        entry.shader  = shader;
                        entry.feat_lo = features_low;
                        entry.feat_hi = features_high;
                        ring[ring_wr] = entry;
                        ring_wr       = (ring_wr + 1) % RING_N;
                        v.queued      = 1'b1;
                    end
                end
            end
        end
    endtask

    task automatic check_field(input string fname, input logic [FEAT_W-1:0] exp_v,
                               input logic [FEAT_W-1:0] got_v);
        if (got_v !== exp_v)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, fname, exp_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_ms_q     = STALE_MS_RST;
            window_q       = REORDER_WINDOW_RST;
            max_hop_q      = MAX_HOP_RST;
            last_seq       = '0;
            seen_any       = 1'b0;
            last_accept_ms = '0;
            ring_rd        = 0;
            ring_wr        = 0;
            for (k = 0; k < SLOTS; k++)
            begin
                nb_used[k]  = 1'b0;
                nb_count[k] = '0;
            end
            verdict_q.delete();
            fail_count   = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_STALE_MS:       stale_ms_q = cfg_data[STALE_W-1:0];
                    CFG_REORDER_WINDOW: window_q   = cfg_data[WINDOW_W-1:0];
                    CFG_MAX_HOP:        max_hop_q  = cfg_data[HOP_W-1:0];
                    default:            ;
                endcase
            end

            if (done)
            begin
                if (verdict_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: result strobe with no request pending", $time);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    check_field("accepted", FEAT_W'(want.accepted), FEAT_W'(accepted));
                    check_field("resync", FEAT_W'(want.resync), FEAT_W'(resync));
                    check_field("relay_queued", FEAT_W'(want.queued), FEAT_W'(relay_queued));
                    check_field("relay_dropped", FEAT_W'(want.dropped),
                                FEAT_W'(relay_dropped));
                    check_field("source_slot", FEAT_W'(want.slot), FEAT_W'(source_slot));
                    check_field("source_count", FEAT_W'(want.count), FEAT_W'(source_count));
                    check_field("relay_valid", FEAT_W'(want.relay_valid),
                                FEAT_W'(relay_valid));
                    check_field("relay_seq", FEAT_W'(want.seq), FEAT_W'(relay_seq));
                    check_field("relay_hop", FEAT_W'(want.hop), FEAT_W'(relay_hop));
                    check_field("relay_shader", FEAT_W'(want.shader), FEAT_W'(relay_shader));
                    check_field("relay_features_low", want.flo, relay_features_low);
                    check_field("relay_features_high", want.fhi, relay_features_high);
                end
            end

            if (start && !busy)
            begin
                predict_verdict(fresh_verdict);
                verdict_q.push_back(fresh_verdict);
            end

            outstanding <= verdict_q.size();
        end
    end

endmodule

FILE: sim/tb_packet_dedupe_and_flood_relay_top.sv
// ----------------------------------------------------------------------------
// tb_packet_dedupe_and_flood_relay_top
// Drives packet and drain requests into the dedupe and relay block through
// several register settings: a directed pass over the acceptance rules, ring
// full and empty, and neighbour table fill, then mostly in-order sequences
// with reorder, duplicate, epoch and silence cases and random idle gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_packet_dedupe_and_flood_relay_top;
    import dfr_pkg::*;

    localparam int SLOT_BITS      = $clog2(NEIGHBOUR_SLOTS_DEF + 1);
    localparam int PHASE_REQUESTS = 110;
    localparam int SETTLE_CYCLES  = 2 * NEIGHBOUR_SLOTS_DEF + 4;
    localparam int MAX_GAP        = 19;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   action;
    logic [TIME_W-1:0]      now_ms;
    logic                   packet_ok;
    logic [MAC_W-1:0]       sender_mac;
    logic [SEQ_W-1:0]       seq;
    logic [HOP_W-1:0]       hop;
    logic [SHADER_W-1:0]    shader;
    logic [FEAT_W-1:0]      features_low;
    logic [FEAT_W-1:0]      features_high;
    logic                   done;
    logic                   accepted;
    logic                   resync;
    logic                   relay_queued;
    logic                   relay_dropped;
    logic [SLOT_BITS-1:0]   source_slot;
    logic [COUNT_W-1:0]     source_count;
    logic                   relay_valid;
    logic [SEQ_W-1:0]       relay_seq;
    logic [HOP_W-1:0]       relay_hop;
    logic [SHADER_W-1:0]    relay_shader;
    logic [FEAT_W-1:0]      relay_features_low;
    logic [FEAT_W-1:0]      relay_features_high;

    int                     outstanding;
    int                     fail_count;

    logic                   no_idle;
    logic [MAC_W-1:0]       mac_pool [NEIGHBOUR_SLOTS_DEF];
    logic [TIME_W-1:0]      clock_ms;
    logic [SEQ_W-1:0]       conductor_seq;
    logic [STALE_W-1:0]     cur_stale;
    logic [WINDOW_W-1:0]    cur_window;
    logic [HOP_W-1:0]       cur_max_hop;
    int                     p;

    packet_dedupe_and_flood_relay_top uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .action              (action),
        .now_ms              (now_ms),
        .packet_ok           (packet_ok),
        .sender_mac          (sender_mac),
        .seq                 (seq),
        .hop                 (hop),
        .shader              (shader),
        .features_low        (features_low),
        .features_high       (features_high),
        .done                (done),
        .accepted            (accepted),
        .resync              (resync),
        .relay_queued        (relay_queued),
        .relay_dropped       (relay_dropped),
        .source_slot         (source_slot),
        .source_count        (source_count),
        .relay_valid         (relay_valid),
        .relay_seq           (relay_seq),
        .relay_hop           (relay_hop),
        .relay_shader        (relay_shader),
        .relay_features_low  (relay_features_low),
        .relay_features_high (relay_features_high)
    );

    dedupe_relay_checker chk (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .action              (action),
        .now_ms              (now_ms),
        .packet_ok           (packet_ok),
        .sender_mac          (sender_mac),
        .seq                 (seq),
        .hop                 (hop),
        .shader              (shader),
        .features_low        (features_low),
        .features_high       (features_high),
        .done                (done),
        .accepted            (accepted),
        .resync              (resync),
        .relay_queued        (relay_queued),
        .relay_dropped       (relay_dropped),
        .source_slot         (source_slot),
        .source_count        (source_count),
        .relay_valid         (relay_valid),
        .relay_seq           (relay_seq),
        .relay_hop           (relay_hop),
        .relay_shader        (relay_shader),
        .relay_features_low  (relay_features_low),
        .relay_features_high (relay_features_high),
        .outstanding         (outstanding),
        .fail_count          (fail_count)
    );

    always #1 clk = ~clk;

    task automatic issue(input logic act, input logic [TIME_W-1:0] t_ms, input logic ok,
                         input logic [MAC_W-1:0] mac, input logic [SEQ_W-1:0] sq,
                         input logic [HOP_W-1:0] hp, input logic [SHADER_W-1:0] sh,
                         input logic [FEAT_W-1:0] flo, input logic [FEAT_W-1:0] fhi);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 24) == 0)
            no_idle = !no_idle;
        @(negedge clk);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action        <= act;
        now_ms        <= t_ms;
        packet_ok     <= ok;
        sender_mac    <= mac;
        seq           <= sq;
        hop           <= hp;
        shader        <= sh;
        features_low  <= flo;
        features_high <= fhi;
        start         <= 1'b1;
        do @(posedge clk); while (busy);
    endtask

    task automatic send_packet(input logic [TIME_W-1:0] t_ms, input logic [MAC_W-1:0] mac,
                               input logic [SEQ_W-1:0] sq, input logic [HOP_W-1:0] hp);
        issue(ACT_PACKET, t_ms, 1'b1, mac, sq, hp, SHADER_W'($urandom),
              {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    task automatic send_drain();
        issue(ACT_DRAIN, $urandom, 1'($urandom), MAC_W'({$urandom, $urandom}),
              SEQ_W'($urandom), HOP_W'($urandom), SHADER_W'($urandom),
              {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_register(input dfr_cfg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_registers(input logic [STALE_W-1:0] stale,
                                     input logic [WINDOW_W-1:0] window,
                                     input logic [HOP_W-1:0] hop_limit);
        write_register(CFG_STALE_MS, stale);
        write_register(CFG_REORDER_WINDOW, CFG_DATA_W'(window));
        write_register(CFG_MAX_HOP, CFG_DATA_W'(hop_limit));
        @(negedge clk);
        cfg_valid   <= 1'b0;
        cur_stale    = stale;
        cur_window   = window;
        cur_max_hop  = hop_limit;
    endtask

    task automatic random_request();
        int                r;
        int                s;
        logic [TIME_W-1:0] step;
        logic [SEQ_W-1:0]  sq;
        logic [MAC_W-1:0]  mac;
        logic [HOP_W-1:0]  hp;
        r = $urandom_range(0, 99);
        if (r < 22)
            send_drain();
        else if (r < 27)
            issue(ACT_PACKET, $urandom, 1'b0, MAC_W'({$urandom, $urandom}),
                  SEQ_W'($urandom), HOP_W'($urandom), SHADER_W'($urandom),
                  {$urandom, $urandom}, {$urandom, $urandom});
        else
        begin
            s = $urandom_range(0, 99);
            if (s < 10)
                step = 0;
            else if (s < 75)
                step = $urandom_range(1, 40);
            else if (s < 85)
                step = cur_stale + $urandom_range(0, 1);
            else if (s < 92)
                step = $urandom_range(0, 2 * cur_stale + 2);
            else
                step = $urandom;
            clock_ms = clock_ms + step;

            s = $urandom_range(0, 99);
            if (s < 55)
            begin
                conductor_seq = conductor_seq + 1'b1;
                sq = conductor_seq;
            end
            else if (s < 65)
            begin
                conductor_seq = SEQ_W'(conductor_seq + $urandom_range(2, 300));
                sq = conductor_seq;
            end
            else if (s < 80)
                sq = SEQ_W'(conductor_seq - $urandom_range(0, 4));
            else if (s < 90)
            begin
                sq = SEQ_W'(conductor_seq - cur_window - 1'b1 + $urandom_range(0, 2));
                conductor_seq = sq;
            end
            else if (s < 95)
            begin
                sq = conductor_seq ^ 16'h8000;
                conductor_seq = sq;
            end
            else
            begin
                sq = SEQ_W'($urandom);
                conductor_seq = sq;
            end

            if ($urandom_range(0, 99) < 70)
                mac = mac_pool[$urandom_range(0, NEIGHBOUR_SLOTS_DEF - 1)];
            else
                mac = MAC_W'({$urandom, $urandom});
            if ($urandom_range(0, 99) < 60)
                hp = HOP_W'($urandom_range(0, 15));
            else
                hp = HOP_W'($urandom_range(0, cur_max_hop));
            send_packet(clock_ms, mac, sq, hp);
        end
    endtask

    task automatic run_phase(input logic [STALE_W-1:0] stale, input logic [WINDOW_W-1:0] window,
                             input logic [HOP_W-1:0] hop_limit);
        wait_idle();
        program_registers(stale, window, hop_limit);
        clock_ms      = $urandom;
        conductor_seq = SEQ_W'($urandom);
        repeat (PHASE_REQUESTS) random_request();
    endtask

    initial
    begin
        #500000;
        $display("packet_dedupe_and_flood_relay_top regression: fail");
        $finish;
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_STALE_MS;
        cfg_data      = '0;
        action        = ACT_PACKET;
        now_ms        = '0;
        packet_ok     = 1'b0;
        sender_mac    = '0;
        seq           = '0;
        hop           = '0;
        shader        = '0;
        features_low  = '0;
        features_high = '0;
        no_idle       = 1'b0;
        mac_pool[0]   = '0;
        mac_pool[1]   = '1;
        for (p = 2; p < NEIGHBOUR_SLOTS_DEF; p++)
            mac_pool[p] = MAC_W'({$urandom, $urandom});

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        program_registers(STALE_MS_RST, REORDER_WINDOW_RST, MAX_HOP_RST);

        // empty ring, invalid request, first packet with time and sequence wrap
        send_drain();
        issue(ACT_PACKET, 32'h0, 1'b0, mac_pool[0], 16'hFFFF, 4'hF, 8'hFF, '1, '1);
        issue(ACT_PACKET, 32'hFFFF_FFF0, 1'b1, mac_pool[0], 16'hFFFF, 4'h0, 8'h00, '0, '0);
        send_packet(32'hFFFF_FFF8, mac_pool[0], 16'hFFFF, 4'd0);
        issue(ACT_PACKET, 32'd4, 1'b1, mac_pool[1], 16'h0000, 4'd2, 8'hFF, '1, '1);
        send_packet(32'd8, mac_pool[1], 16'hFFFE, 4'd1);
        // hop at and above the limit, then fill the ring and overflow it
        send_packet(32'd12, mac_pool[0], 16'd1, 4'd3);
        send_packet(32'd16, mac_pool[1], 16'd2, 4'd15);
        send_packet(32'd20, mac_pool[0], 16'd3, 4'd1);
        send_packet(32'd24, mac_pool[1], 16'd4, 4'd0);
        repeat (4) send_drain();
        // reorder window edge, silence edge, half-range lag
        send_packet(32'd30, mac_pool[2], 16'hFF04, 4'd0);
        send_packet(32'd32, mac_pool[2], 16'hFF03, 4'd0);
        send_packet(32'd332, mac_pool[3], 16'hFF03, 4'd0);
        send_packet(32'd333, mac_pool[3], 16'hFF03, 4'd0);
        send_packet(32'd334, mac_pool[4], 16'h7F03, 4'd0);
        // fill the neighbour table, then an unknown sender and a known one
        send_packet(32'd335, mac_pool[5], 16'h7F04, 4'd0);
        send_packet(32'd336, mac_pool[6], 16'h7F05, 4'd0);
        send_packet(32'd337, mac_pool[7], 16'h7F06, 4'd0);
        send_packet(32'd338, MAC_W'({$urandom, $urandom}), 16'h7F07, 4'd0);
        send_packet(32'd339, mac_pool[3], 16'h7F08, 4'd0);

        run_phase(16'd0, 15'd0, 4'd15);
        run_phase(16'hFFFF, 15'h7FFF, 4'd0);
        run_phase(16'd1000, 15'd100, 4'd8);
        run_phase(STALE_W'($urandom_range(0, 2000)), WINDOW_W'($urandom_range(0, 32767)),
                  HOP_W'($urandom_range(0, 15)));
        run_phase(16'd40, 15'd2000, 4'd4);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("packet_dedupe_and_flood_relay_top regression: pass");
        else
            $display("packet_dedupe_and_flood_relay_top regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
sv/dfr_pkg.sv
sv/dfr_ram.sv
sv/dfr_ctrl.sv
sv/dfr_datapath.sv
sv/packet_dedupe_and_flood_relay_top.sv
sv/dfr_checker.sv
sim/dedupe_relay_checker.sv
sim/tb_packet_dedupe_and_flood_relay_top.sv
